FILE: hdl/bes_pkg.sv
// Shared types, constants and constant tables of the buzzer effect sequencer.
package bes_pkg;

  localparam int QUEUE_SLOTS_DEF    = 6;
  localparam int NOTE_ROM_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF      = 16;

  localparam logic       FUNC_TICK      = 1'b0;
  localparam logic       FUNC_PLAY      = 1'b1;
  localparam logic [3:0] CODE_EXPLOSION = 4'd4;
  localparam logic [3:0] CODE_WIN       = 4'd5;

  typedef struct packed {
    logic       func;
    logic [3:0] event_code;
  } item_t;

  typedef struct packed {
    logic [11:0] tone_freq;
    logic        tone_on;
    logic        busy_res;
    logic [2:0]  queued_count;
  } result_t;

  typedef struct packed {
    logic [11:0] freq;
    logic [7:0]  dur;
    logic [6:0]  pause;
  } note_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] start;
  } list_start_t;

  // Start address of each effect's note list.
  function automatic list_start_t list_start(input logic [3:0] code);
    list_start_t s;
    s.valid = 1'b1;
    case (code)
      4'd1:    s.start = 8'd0;
      4'd2:    s.start = 8'd3;
      4'd3:    s.start = 8'd6;
      4'd4:    s.start = 8'd10;
      4'd5:    s.start = 8'd19;
      4'd6:    s.start = 8'd26;
      4'd7:    s.start = 8'd33;
      4'd8:    s.start = 8'd41;
      4'd9:    s.start = 8'd45;
      4'd10:   s.start = 8'd50;
      4'd11:   s.start = 8'd55;
      4'd12:   s.start = 8'd58;
      4'd13:   s.start = 8'd61;
      default: begin
        s.valid = 1'b0;
        s.start = 8'd0;
      end
    endcase
    return s;
  endfunction

  // Note table; every address not listed reads as an end entry.
  function automatic note_t note_rom(input logic [7:0] addr);
    note_t n;
    case (addr)
      8'd0:    n = '{12'd1250, 8'd7, 7'd0};
      8'd1:    n = '{12'd1650, 8'd6, 7'd0};
      8'd3:    n = '{12'd620, 8'd10, 7'd3};
      8'd4:    n = '{12'd880, 8'd8, 7'd0};
      8'd6:    n = '{12'd900, 8'd7, 7'd3};
      8'd7:    n = '{12'd1200, 8'd7, 7'd3};
      8'd8:    n = '{12'd1550, 8'd9, 7'd0};
      8'd10:   n = '{12'd820, 8'd14, 7'd0};
      8'd11:   n = '{12'd520, 8'd22, 7'd0};
      8'd12:   n = '{12'd300, 8'd34, 7'd0};
      8'd13:   n = '{12'd360, 8'd20, 7'd0};
      8'd14:   n = '{12'd200, 8'd50, 7'd0};
      8'd15:   n = '{12'd120, 8'd80, 7'd0};
      8'd16:   n = '{12'd150, 8'd30, 7'd0};
      8'd17:   n = '{12'd80, 8'd150, 7'd0};
      8'd19:   n = '{12'd600, 8'd80, 7'd16};
      8'd20:   n = '{12'd760, 8'd80, 7'd16};
      8'd21:   n = '{12'd1010, 8'd80, 7'd16};
      8'd22:   n = '{12'd1280, 8'd90, 7'd16};
      8'd23:   n = '{12'd1600, 8'd130, 7'd22};
      8'd24:   n = '{12'd1280, 8'd170, 7'd0};
      8'd26:   n = '{12'd480, 8'd15, 7'd0};
      8'd27:   n = '{12'd720, 8'd15, 7'd0};
      8'd28:   n = '{12'd1040, 8'd16, 7'd0};
      8'd29:   n = '{12'd1420, 8'd20, 7'd0};
      8'd30:   n = '{12'd1820, 8'd34, 7'd0};
      8'd31:   n = '{12'd1520, 8'd22, 7'd0};
      8'd33:   n = '{12'd2000, 8'd11, 7'd0};
      8'd34:   n = '{12'd1450, 8'd9, 7'd0};
      8'd35:   n = '{12'd1900, 8'd9, 7'd0};
      8'd36:   n = '{12'd1150, 8'd11, 7'd0};
      8'd37:   n = '{12'd1700, 8'd9, 7'd0};
      8'd38:   n = '{12'd900, 8'd14, 7'd0};
      8'd39:   n = '{12'd560, 8'd30, 7'd0};
      8'd41:   n = '{12'd700, 8'd34, 7'd8};
      8'd42:   n = '{12'd950, 8'd38, 7'd8};
      8'd43:   n = '{12'd1250, 8'd60, 7'd0};
      8'd45:   n = '{12'd900, 8'd38, 7'd6};
      8'd46:   n = '{12'd1200, 8'd42, 7'd6};
      8'd47:   n = '{12'd1520, 8'd55, 7'd10};
      8'd48:   n = '{12'd1150, 8'd120, 7'd0};
      8'd50:   n = '{12'd900, 8'd8, 7'd0};
      8'd51:   n = '{12'd1650, 8'd20, 7'd55};
      8'd52:   n = '{12'd1500, 8'd12, 7'd120};
      8'd53:   n = '{12'd1150, 8'd10, 7'd0};
      8'd55:   n = '{12'd700, 8'd30, 7'd10};
      8'd56:   n = '{12'd1000, 8'd42, 7'd0};
      8'd58:   n = '{12'd950, 8'd30, 7'd10};
      8'd59:   n = '{12'd620, 8'd42, 7'd0};
      8'd61:   n = '{12'd1050, 8'd6, 7'd0};
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/bes_ring.sv
// Event ring memory with a registered head word that always holds the entry at the read index.
module bes_ring #(
  parameter int QUEUE_SLOTS = 6,
  parameter int IW          = $clog2(QUEUE_SLOTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [3:0]    wdata,
  input  logic [IW-1:0] raddr,
  output logic [3:0]    head
);

  logic [3:0] mem [QUEUE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read address is the read index of the next cycle; a write to that
  // same slot is forwarded so the head word is never stale.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      head <= wdata;
    end else begin
      head <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bes_core.sv
// Sequencer state and the per-transaction update of ring indices and note playback.
module bes_core #(
  parameter int QUEUE_SLOTS    = 6,
  parameter int NOTE_ROM_DEPTH = 64,
  parameter int TIME_BITS      = 16,
  parameter int IW             = $clog2(QUEUE_SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  bes_pkg::item_t          item,
  input  logic                    cfg_fire,
  input  logic                    cfg_data,
  input  logic [3:0]              head,
  output logic                    we,
  output logic [IW-1:0]           waddr,
  output logic [3:0]              wdata,
  output logic [IW-1:0]           raddr,
  output bes_pkg::result_t        result
);
  import bes_pkg::*;

  localparam int PW = $clog2(NOTE_ROM_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_SLOTS - 1);

  logic                 sound_enable, sound_enable_next;
  logic                 playing, playing_next;
  logic [PW-1:0]        note_pointer, note_pointer_next;
  logic                 in_tone_phase, in_tone_phase_next;
  logic [TIME_BITS-1:0] elapsed_ms, elapsed_ms_next;
  logic [IW-1:0]        wr_index, wr_index_next;
  logic [IW-1:0]        rd_index, rd_index_next;
  logic [11:0]          tone_register, tone_register_next;

  list_start_t          start_info;
  note_t                cur_note;
  note_t                follow_note;
  logic [IW-1:0]        wr_inc;
  logic                 started;
  logic [IW:0]          count;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
    return (x == LAST_SLOT) ? '0 : x + 1'b1;
  endfunction

  always_comb begin
    sound_enable_next  = sound_enable;
    playing_next       = playing;
    note_pointer_next  = note_pointer;
    in_tone_phase_next = in_tone_phase;
    elapsed_ms_next    = elapsed_ms;
    wr_index_next      = wr_index;
    rd_index_next      = rd_index;
    tone_register_next = tone_register;
    we                 = 1'b0;
    waddr              = wr_index;
    wdata              = item.event_code;
    started            = 1'b0;
    start_info         = list_start(item.event_code);
    wr_inc             = '0;
    cur_note           = '0;
    follow_note        = '0;

    if (cfg_fire) begin
      sound_enable_next = cfg_data;
      if (!cfg_data) begin
        tone_register_next = '0;
        playing_next       = 1'b0;
        wr_index_next      = '0;
        rd_index_next      = '0;
      end
    end else if (in_fire && (item.func == FUNC_PLAY)) begin
      if (sound_enable && start_info.valid) begin
        // Priority effects flush whatever is playing or waiting.
        if ((item.event_code == CODE_EXPLOSION) || (item.event_code == CODE_WIN)) begin
          tone_register_next = '0;
          playing_next       = 1'b0;
          wr_index_next      = '0;
          rd_index_next      = '0;
        end
        waddr  = wr_index_next;
        we     = 1'b1;
        wr_inc = ring_inc(wr_index_next);
        if (wr_inc == rd_index_next) begin
          rd_index_next = ring_inc(rd_index_next);
        end
        wr_index_next = wr_inc;
      end
    end else if (in_fire) begin
      if (!sound_enable) begin
        tone_register_next = '0;
        playing_next       = 1'b0;
        wr_index_next      = '0;
        rd_index_next      = '0;
      end else begin
        start_info = list_start(head);
        if (!playing && (rd_index != wr_index)) begin
          rd_index_next = ring_inc(rd_index);
          if (start_info.valid) begin
            playing_next       = 1'b1;
            note_pointer_next  = PW'(start_info.start);
            in_tone_phase_next = 1'b1;
            elapsed_ms_next    = '0;
            started            = 1'b1;
          end
        end
        cur_note    = note_rom(8'(note_pointer_next));
        follow_note = note_rom(8'(note_pointer_next + 1'b1));
        if (started) begin
          tone_register_next = (cur_note.dur != '0) ? cur_note.freq : '0;
        end
        if (playing_next) begin
          if (!started && (elapsed_ms != '1)) begin
            elapsed_ms_next = elapsed_ms + 1'b1;
          end
          if (cur_note.dur == '0) begin
            tone_register_next = '0;
            playing_next       = 1'b0;
          end else if (in_tone_phase_next) begin
            if (elapsed_ms_next >= TIME_BITS'(cur_note.dur)) begin
              tone_register_next = '0;
              in_tone_phase_next = 1'b0;
              elapsed_ms_next    = '0;
              if (cur_note.pause == '0) begin
                note_pointer_next  = note_pointer_next + 1'b1;
                in_tone_phase_next = 1'b1;
                tone_register_next = (follow_note.dur != '0) ? follow_note.freq : '0;
              end
            end
          end else if (elapsed_ms_next >= TIME_BITS'(cur_note.pause)) begin
            note_pointer_next  = note_pointer_next + 1'b1;
            in_tone_phase_next = 1'b1;
            elapsed_ms_next    = '0;
            tone_register_next = (follow_note.dur != '0) ? follow_note.freq : '0;
          end
        end
      end
    end

    raddr = rd_index_next;

    if (wr_index_next >= rd_index_next) begin
      count = {1'b0, wr_index_next} - {1'b0, rd_index_next};
    end else begin
      count = {1'b0, wr_index_next} + (IW + 1)'(QUEUE_SLOTS) - {1'b0, rd_index_next};
    end
    result.tone_freq    = tone_register_next;
    result.tone_on      = (tone_register_next != '0);
    result.busy_res     = playing_next;
    result.queued_count = 3'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable  <= 1'b1;
      playing       <= 1'b0;
      note_pointer  <= '0;
      in_tone_phase <= 1'b0;
      elapsed_ms    <= '0;
      wr_index      <= '0;
      rd_index      <= '0;
      tone_register <= '0;
    end else begin
      sound_enable  <= sound_enable_next;
      playing       <= playing_next;
      note_pointer  <= note_pointer_next;
      in_tone_phase <= in_tone_phase_next;
      elapsed_ms    <= elapsed_ms_next;
      wr_index      <= wr_index_next;
      rd_index      <= rd_index_next;
      tone_register <= tone_register_next;
    end
  end

endmodule

FILE: hdl/buzzer_effect_sequencer_top.sv
// Top level of the buzzer effect sequencer: ring memory, sequencer core and output register.
//
// Usage: each input transaction on in_valid/in_ready carries func and event_code.
// func = 0 is a one millisecond tick, func = 1 queues a play event. Every input
// transaction yields exactly one result transaction on out_valid/out_ready with
// the tone frequency, tone_on, busy_res and the number of queued events.
// The cfg channel writes the one-bit sound_enable register; writing 0 mutes the
// buzzer, stops playback and empties the event ring. cfg_ready is always high.
// The result of a transaction is held in the output register. Throughput
// is one transaction per cycle while the receiver takes each result; the
// per-item update is a single pass through the note table, the ring indices
// and the registered head word of the ring memory.
// Synchronous reset rst clears playback, the ring indices and the tone, and
// sets sound_enable to 1. When the receiver stalls, the result stays in the
// output register and in_ready drops until it is taken; a new transaction is
// accepted in the same cycle that the waiting result leaves.
module buzzer_effect_sequencer_top #(
  parameter int QUEUE_SLOTS    = bes_pkg::QUEUE_SLOTS_DEF,
  parameter int NOTE_ROM_DEPTH = bes_pkg::NOTE_ROM_DEPTH_DEF,
  parameter int TIME_BITS      = bes_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bes_pkg::item_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bes_pkg::result_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import bes_pkg::*;

  localparam int IW = $clog2(QUEUE_SLOTS);

  logic          in_fire;
  logic          cfg_fire;
  logic          we;
  logic [IW-1:0] waddr;
  logic [3:0]    wdata;
  logic [IW-1:0] raddr;
  logic [3:0]    head;
  result_t       result;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  bes_ring #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .IW          (IW)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .head  (head)
  );

  bes_core #(
    .QUEUE_SLOTS    (QUEUE_SLOTS),
    .NOTE_ROM_DEPTH (NOTE_ROM_DEPTH),
    .TIME_BITS      (TIME_BITS),
    .IW             (IW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .item     (in_data),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_data),
    .head     (head),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

endmodule

FILE: test/buzzer_effect_sequencer_checker.sv
// Checker for the buzzer effect sequencer: predicts each result and compares it.
`timescale 1ns / 100ps

module buzzer_effect_sequencer_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  bes_pkg::item_t   in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  bes_pkg::result_t out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_data,
  output int               errors,
  output int               pending
);
  import bes_pkg::*;

  localparam int          SLOTS       = 6;
  localparam int          NOTE_COUNT  = 63;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [7:0]  NO_LIST     = 8'hFF;

  // Each entry is {frequency, duration, pause}.
  localparam logic [27:0] NOTE_TABLE [NOTE_COUNT] = '{
    {12'd1250, 8'd7, 8'd0}, {12'd1650, 8'd6, 8'd0}, 28'd0,
    {12'd620, 8'd10, 8'd3}, {12'd880, 8'd8, 8'd0}, 28'd0,
    {12'd900, 8'd7, 8'd3}, {12'd1200, 8'd7, 8'd3}, {12'd1550, 8'd9, 8'd0}, 28'd0,
    {12'd820, 8'd14, 8'd0}, {12'd520, 8'd22, 8'd0}, {12'd300, 8'd34, 8'd0},
    {12'd360, 8'd20, 8'd0}, {12'd200, 8'd50, 8'd0}, {12'd120, 8'd80, 8'd0},
    {12'd150, 8'd30, 8'd0}, {12'd80, 8'd150, 8'd0}, 28'd0,
    {12'd600, 8'd80, 8'd16}, {12'd760, 8'd80, 8'd16}, {12'd1010, 8'd80, 8'd16},
    {12'd1280, 8'd90, 8'd16}, {12'd1600, 8'd130, 8'd22}, {12'd1280, 8'd170, 8'd0},
    28'd0,
    {12'd480, 8'd15, 8'd0}, {12'd720, 8'd15, 8'd0}, {12'd1040, 8'd16, 8'd0},
    {12'd1420, 8'd20, 8'd0}, {12'd1820, 8'd34, 8'd0}, {12'd1520, 8'd22, 8'd0},
    28'd0,
    {12'd2000, 8'd11, 8'd0}, {12'd1450, 8'd9, 8'd0}, {12'd1900, 8'd9, 8'd0},
    {12'd1150, 8'd11, 8'd0}, {12'd1700, 8'd9, 8'd0}, {12'd900, 8'd14, 8'd0},
    {12'd560, 8'd30, 8'd0}, 28'd0,
    {12'd700, 8'd34, 8'd8}, {12'd950, 8'd38, 8'd8}, {12'd1250, 8'd60, 8'd0}, 28'd0,
    {12'd900, 8'd38, 8'd6}, {12'd1200, 8'd42, 8'd6}, {12'd1520, 8'd55, 8'd10},
    {12'd1150, 8'd120, 8'd0}, 28'd0,
    {12'd900, 8'd8, 8'd0}, {12'd1650, 8'd20, 8'd55}, {12'd1500, 8'd12, 8'd120},
    {12'd1150, 8'd10, 8'd0}, 28'd0,
    {12'd700, 8'd30, 8'd10}, {12'd1000, 8'd42, 8'd0}, 28'd0,
    {12'd950, 8'd30, 8'd10}, {12'd620, 8'd42, 8'd0}, 28'd0,
    {12'd1050, 8'd6, 8'd0}, 28'd0
  };

  localparam logic [7:0] LIST_START [16] = '{
    NO_LIST, 8'd0, 8'd3, 8'd6, 8'd10, 8'd19, 8'd26, 8'd33,
    8'd41, 8'd45, 8'd50, 8'd55, 8'd58, 8'd61, NO_LIST, NO_LIST
  };

  logic        sound_on;
  logic        playing;
  int          note_idx;
  logic        tone_phase;
  logic [15:0] elapsed;
  logic [3:0]  ring [SLOTS];
  int          wr_slot;
  int          rd_slot;
  logic [11:0] tone;

  result_t expected_results[$];

  function automatic logic [27:0] note_at(input int addr);
    if (addr < 0 || addr >= NOTE_COUNT) return '0;
    return NOTE_TABLE[addr];
  endfunction

  function automatic void load_tone();
    logic [27:0] note;
    note = note_at(note_idx);
    tone = (note[27:16] != 0 && note[15:8] != 0) ? note[27:16] : '0;
  endfunction

  function automatic void next_note();
    note_idx++;
    tone_phase = 1'b1;
    elapsed = '0;
    load_tone();
  endfunction

  function automatic void silence_all();
    tone = '0;
    playing = 1'b0;
    wr_slot = 0;
    rd_slot = 0;
  endfunction

  function automatic void queue_event(input logic [3:0] code);
    int nxt;
    if (!sound_on || LIST_START[code] == NO_LIST) return;
    if (code == CODE_EXPLOSION || code == CODE_WIN) silence_all();
    nxt = (wr_slot + 1) % SLOTS;
    // A full ring gives up its oldest event.
    if (nxt == rd_slot) rd_slot = (rd_slot + 1) % SLOTS;
    ring[wr_slot] = code;
    wr_slot = nxt;
  endfunction

  function automatic void step_tick();
    logic [27:0] note;
    logic [7:0]  start;
    logic [7:0]  dur;
    logic [7:0]  pau;
    bit          started;
    started = 1'b0;
    if (!sound_on) begin
      silence_all();
      return;
    end
    if (!playing && rd_slot != wr_slot) begin
      start = LIST_START[ring[rd_slot]];
      rd_slot = (rd_slot + 1) % SLOTS;
      if (start != NO_LIST) begin
        playing = 1'b1;
        note_idx = start;
        tone_phase = 1'b1;
        elapsed = '0;
        load_tone();
        started = 1'b1;
      end
    end
    if (!playing) return;
    // The tick that starts a list is time zero of its first note.
    if (!started && elapsed != ELAPSED_MAX) elapsed++;
    note = note_at(note_idx);
    dur = note[15:8];
    pau = note[7:0];
    if (dur == 0) begin
      tone = '0;
      playing = 1'b0;
      return;
    end
    if (tone_phase) begin
      if (elapsed >= dur) begin
        tone = '0;
        tone_phase = 1'b0;
        elapsed = '0;
        if (pau == 0) next_note();
      end
    end else if (elapsed >= pau) begin
      next_note();
    end
  endfunction

  function automatic result_t current_result();
    result_t r;
    r.tone_freq = tone;
    r.tone_on = (tone != 0);
    r.busy_res = playing;
    r.queued_count = 3'((wr_slot + SLOTS - rd_slot) % SLOTS);
    return r;
  endfunction

  function automatic void report_field(input string name, input logic [11:0] want,
                                       input logic [11:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    errors++;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      sound_on = 1'b1;
      playing = 1'b0;
      note_idx = 0;
      tone_phase = 1'b0;
      elapsed = '0;
      for (int i = 0; i < SLOTS; i++) ring[i] = '0;
      wr_slot = 0;
      rd_slot = 0;
      tone = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sound_on = cfg_data;
        if (!sound_on) silence_all();
      end
      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_PLAY) queue_event(in_data.event_code);
        else step_tick();
        expected_results.push_back(current_result());
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.tone_freq !== want.tone_freq)
            report_field("tone_freq", want.tone_freq, out_data.tone_freq);
          if (out_data.tone_on !== want.tone_on)
            report_field("tone_on", want.tone_on, out_data.tone_on);
          if (out_data.busy_res !== want.busy_res)
            report_field("busy_res", want.busy_res, out_data.busy_res);
          if (out_data.queued_count !== want.queued_count)
            report_field("queued_count", want.queued_count, out_data.queued_count);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: test/buzzer_effect_sequencer_top_test.sv
// Testbench top of the buzzer effect sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module buzzer_effect_sequencer_top_test;
  import bes_pkg::*;

  localparam logic [3:0] CODE_NONE       = 4'd0;
  localparam logic [3:0] CODE_REVEAL     = 4'd1;
  localparam logic [3:0] CODE_FLAG       = 4'd2;
  localparam logic [3:0] CODE_CHORD      = 4'd3;
  localparam logic [3:0] CODE_BURST      = 4'd6;
  localparam logic [3:0] CODE_LIGHTNING  = 4'd7;
  localparam logic [3:0] CODE_ARM        = 4'd8;
  localparam logic [3:0] CODE_SAVE       = 4'd9;
  localparam logic [3:0] CODE_SONAR      = 4'd10;
  localparam logic [3:0] CODE_MODE_EXIT  = 4'd12;
  localparam logic [3:0] CODE_CLICK      = 4'd13;
  localparam logic [3:0] CODE_SPARE_LO   = 4'd14;
  localparam logic [3:0] CODE_SPARE_HI   = 4'd15;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  item_t   in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_data;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic    cfg_data = 1'b0;
  int      errors;
  int      pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  buzzer_effect_sequencer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  buzzer_effect_sequencer_checker u_effect_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  function automatic logic [3:0] short_code();
    case ($urandom_range(3, 0))
      0: return CODE_REVEAL;
      1: return CODE_FLAG;
      2: return CODE_CHORD;
      default: return CODE_CLICK;
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    it.func = FUNC_TICK;
    it.event_code = 4'($urandom_range(15, 0));
    if ($urandom_range(99, 0) < 7) begin
      it.func = FUNC_PLAY;
      r = $urandom_range(99, 0);
      if (r < 55) it.event_code = short_code();
      else if (r < 85) it.event_code = 4'($urandom_range(CODE_MODE_EXIT + 0, CODE_BURST + 0));
      else if (r < 88) it.event_code = $urandom_range(1, 0) ? CODE_WIN : CODE_EXPLOSION;
    end
    return it;
  endfunction

  // Leaves valid high after acceptance; the caller's next drive decides its level.
  task automatic send_item(input item_t it);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic play(input logic [3:0] code);
    send_item('{func: FUNC_PLAY, event_code: code});
  endtask

  task automatic tick_run(input int count);
    for (int i = 0; i < count; i++)
      send_item('{func: FUNC_TICK, event_code: 4'($urandom_range(15, 0))});
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_sound(input logic on);
    in_valid <= 1'b0;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= on;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n_items, input int hold_at);
    int sent;
    int burst;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      if (hold_at > 0 && !held && sent >= hold_at) begin
        // Hold the sender until every result is out.
        in_valid <= 1'b0;
        drain();
        held = 1'b1;
      end
      if ($urandom_range(99, 0) < 2) begin
        // A burst of plays can overflow the ring.
        burst = $urandom_range(8, 5);
        for (int k = 0; k < burst; k++) play(short_code());
        sent += burst;
      end else begin
        send_item(random_item());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 85;
    set_sound(1'b1);
    play(CODE_NONE);
    play(CODE_SPARE_LO);
    play(CODE_SPARE_HI);
    play(CODE_CLICK);
    tick_run(9);
    play(CODE_REVEAL);
    play(CODE_FLAG);
    play(CODE_CHORD);
    play(CODE_BURST);
    play(CODE_LIGHTNING);
    play(CODE_ARM);
    tick_run(1);
    play(CODE_EXPLOSION);
    tick_run(1);
    play(CODE_WIN);
    tick_run(1);
    set_sound(1'b0);
    play(CODE_SAVE);
    tick_run(1);
    set_sound(1'b1);
    play(CODE_SONAR);
    run_random(360, 0);

    set_sound(1'b0);
    run_random(60, 0);
    set_sound(1'b1);

    send_idle_pct = 85;
    recv_idle_pct = 29;
    run_random(400, 200);

    // Muting in the middle of an effect flushes everything at once.
    set_sound(1'b0);
    set_sound(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300, 0);

    in_valid <= 1'b0;
    drain();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bes_pkg.sv
hdl/bes_ring.sv
hdl/bes_core.sv
hdl/buzzer_effect_sequencer_top.sv
test/buzzer_effect_sequencer_checker.sv
test/buzzer_effect_sequencer_top_test.sv
